/* sv/timed_task_dispatch_table_top_assert.svh */
// Assertion macros for the timed task dispatch table.
// Both macros compile to nothing when SYNTHESIS is defined.
`ifndef TIMED_TASK_DISPATCH_TABLE_TOP_ASSERT_SVH
`define TIMED_TASK_DISPATCH_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define TTD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define TTD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define TTD_ASSERT(lbl, clk, rst, prop, msg)
`define TTD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/ttd_pkg.sv */
package ttd_pkg;

   // Default sizes of the table and of the time fields.
   localparam int DEPTH_DEFAULT      = 16;
   localparam int TIME_WIDTH_DEFAULT = 32;

   // Width of a task handle.
   localparam int ID_WIDTH = 8;

   // Request kinds.
   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   // Response status codes.
   localparam logic [1:0] STATUS_ADDED      = 2'd0;
   localparam logic [1:0] STATUS_DISPATCHED = 2'd1;
   localparam logic [1:0] STATUS_NONE_DUE   = 2'd2;
   localparam logic [1:0] STATUS_FULL       = 2'd3;

   // Timing verdict for one table entry.
   typedef struct packed {
      logic is_due;
      logic is_early;
   } eval_flags_type;

endpackage

/* sv/ttd_table_mem.sv */
module ttd_table_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 72
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Single read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ttd_entry_eval.sv */
module ttd_entry_eval #(
   parameter int TIME_WIDTH = 32
) (
   input  logic [TIME_WIDTH-1:0] now,
   input  logic [TIME_WIDTH-1:0] due,
   input  logic [TIME_WIDTH-1:0] window,
   output ttd_pkg::eval_flags_type flags
);

   import ttd_pkg::*;

   logic [TIME_WIDTH:0] diff;

   // One widened subtract gives both verdicts: a borrow or zero means now >= due,
   // otherwise the remaining gap is compared against the early window without wrap.
   assign diff = {1'b0, due} - {1'b0, now};

   always_comb begin
      flags.is_due   = diff[TIME_WIDTH] || (diff == '0);
      flags.is_early = flags.is_due || (window >= diff[TIME_WIDTH-1:0]);
   end

endmodule

/* sv/timed_task_dispatch_table_top.sv */
// Add request or poll of an empty table: result strobed on the next cycle.
// Poll request with N entries held, dispatching entry P: the table memory is read one
// entry per cycle, first a full scan of all N entries and then a close-up pass that moves
// the entries after P up one place; busy is high throughout.
// Results last one cycle; the receiver cannot stall.
// Synchronous active-high reset clears the entry count and control; entries are not cleared.
`include "timed_task_dispatch_table_top_assert.svh"

module timed_task_dispatch_table_top #(
   parameter int DEPTH      = ttd_pkg::DEPTH_DEFAULT,
   parameter int TIME_WIDTH = ttd_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [ttd_pkg::ID_WIDTH-1:0]     req_task_id,
   input  logic [TIME_WIDTH-1:0]            req_due_time,
   input  logic [TIME_WIDTH-1:0]            req_early_window,
   input  logic [TIME_WIDTH-1:0]            req_now,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic [ttd_pkg::ID_WIDTH-1:0]     rsp_chosen_id,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_used_entries
);

   import ttd_pkg::*;

   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ENT_W  = ID_WIDTH + 2 * TIME_WIDTH;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [AW-1:0]         rd_pos_ff, rd_pos_in;
   logic                  due_found_ff, due_found_in;
   logic [AW-1:0]         due_idx_ff, due_idx_in;
   logic [ID_WIDTH-1:0]   due_tag_ff, due_tag_in;
   logic                  early_found_ff, early_found_in;
   logic [AW-1:0]         early_idx_ff, early_idx_in;
   logic [ID_WIDTH-1:0]   early_tag_ff, early_tag_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [ID_WIDTH-1:0]   rsp_id_ff, rsp_id_in;
   logic [CNT_W-1:0]      rsp_used_ff, rsp_used_in;

   logic                  req_fire;
   logic                  scan_done;
   logic [AW-1:0]         pick_idx;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [ENT_W-1:0]      mem_wdata;
   logic                  mem_re;
   logic [ENT_W-1:0]      mem_rdata;
   logic [ID_WIDTH-1:0]   rd_id;
   eval_flags_type        flags;

   ttd_table_mem #(
      .DEPTH (DEPTH),
      .WIDTH (ENT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   ttd_entry_eval #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_eval (
      .now    (now_ff),
      .due    (mem_rdata[2*TIME_WIDTH-1:TIME_WIDTH]),
      .window (mem_rdata[TIME_WIDTH-1:0]),
      .flags  (flags)
   );

   assign busy      = (state_ff != S_IDLE);
   assign req_fire  = start && !busy;
   assign scan_done = (rd_idx_ff == count_ff) && !rd_pend_ff;
   assign rd_id     = mem_rdata[ENT_W-1 -: ID_WIDTH];
   assign pick_idx  = due_found_ff ? due_idx_ff : early_idx_ff;

   // Request sequencing, table scan and close-up pass.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_idx_in      = rd_idx_ff;
      rd_pend_in     = 1'b0;
      rd_pos_in      = rd_pos_ff;
      due_found_in   = due_found_ff;
      due_idx_in     = due_idx_ff;
      due_tag_in     = due_tag_ff;
      early_found_in = early_found_ff;
      early_idx_in   = early_idx_ff;
      early_tag_in   = early_tag_ff;
      now_in         = now_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_used_in    = rsp_used_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      mem_re         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_type == REQ_ADD) begin
                  rsp_strobe_in = 1'b1;
                  rsp_id_in     = '0;
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     rsp_status_in = STATUS_FULL;
                     rsp_used_in   = count_ff;
                  end else begin
                     mem_we        = 1'b1;
                     mem_waddr     = count_ff[AW-1:0];
                     mem_wdata     = {req_task_id, req_due_time, req_early_window};
                     count_in      = count_ff + 1'b1;
                     rsp_status_in = STATUS_ADDED;
                     rsp_used_in   = count_ff + 1'b1;
                  end
               end else begin
                  now_in = req_now;
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_NONE_DUE;
                     rsp_id_in     = '0;
                     rsp_used_in   = count_ff;
                  end else begin
                     state_in       = S_SCAN;
                     rd_idx_in      = '0;
                     due_found_in   = 1'b0;
                     early_found_in = 1'b0;
                  end
               end
            end
         end

         S_SCAN: begin
            // Issue one read per cycle, judge the entry when its data returns.
            if (rd_idx_ff < count_ff) begin
               mem_re     = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_pos_in  = rd_idx_ff[AW-1:0];
            end
            if (rd_pend_ff) begin
               if (flags.is_due && !due_found_ff) begin
                  due_found_in = 1'b1;
                  due_idx_in   = rd_pos_ff;
                  due_tag_in   = rd_id;
               end
               if (flags.is_early && !early_found_ff) begin
                  early_found_in = 1'b1;
                  early_idx_in   = rd_pos_ff;
                  early_tag_in   = rd_id;
               end
            end
            if (scan_done) begin
               if (due_found_ff || early_found_ff) begin
                  state_in  = S_SHIFT;
                  rd_idx_in = CNT_W'(pick_idx) + 1'b1;
                  rsp_id_in = due_found_ff ? due_tag_ff : early_tag_ff;
               end else begin
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_NONE_DUE;
                  rsp_id_in     = '0;
                  rsp_used_in   = count_ff;
               end
            end
         end

         S_SHIFT: begin
            // Move each later entry up one place to close the gap.
            if (rd_idx_ff < count_ff) begin
               mem_re     = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_pos_in  = rd_idx_ff[AW-1:0];
            end
            if (rd_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_pos_ff - 1'b1;
               mem_wdata = mem_rdata;
            end
            if (scan_done) begin
               state_in      = S_IDLE;
               count_in      = count_ff - 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_DISPATCHED;
               rsp_used_in   = count_ff - 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      rd_pos_ff      <= rd_pos_in;
      due_found_ff   <= due_found_in;
      due_idx_ff     <= due_idx_in;
      due_tag_ff     <= due_tag_in;
      early_found_ff <= early_found_in;
      early_idx_ff   <= early_idx_in;
      early_tag_ff   <= early_tag_in;
      now_ff         <= now_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_id    = rsp_id_ff;
   assign rsp_used_entries = rsp_used_ff;

   // The entry count never passes the table depth.
   `TTD_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "entry count above depth")

   // Every result is strobed while the sequencer is idle.
   `TTD_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_strobe, state_ff == S_IDLE, "result while busy")

   // Only a dispatch returns a nonzero handle.
   `TTD_ASSERT_IMPL(a_rsp_id_zero, clock, reset,
                    rsp_strobe && (rsp_status != STATUS_DISPATCHED),
                    rsp_chosen_id == '0, "handle on non-dispatch result")

   // A poll of a nonempty table starts a scan.
   `TTD_ASSERT(a_poll_scan, clock, reset,
               (req_fire && (req_type == REQ_POLL) && (count_ff != '0)) |=> (state_ff == S_SCAN),
               "poll did not start scan")

endmodule
